FILE: design/ptd_pkg.sv
// Shared constants, types and helpers for the packet type demux table.
package ptd_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int PATTERN_BYTES = 10;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int HND_W    = 4;
  localparam int LEN_W    = 4;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int PAT_W    = 80;
  localparam int PAT_BYTES_MAX = PAT_W / 8;

  // Frame type/length word at or above this marks an Ethernet II header
  localparam logic [15:0] ETHER_II_MIN = 16'd1536;

  // Commands
  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP      = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd3;

  // One table entry
  typedef struct packed {
    logic [HND_W-1:0] handle;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pattern;
  } entry_t;

  // Request data broadcast to every cell for comparison
  typedef struct packed {
    logic [HND_W-1:0] handle;
    logic [PAT_W-1:0] pattern;
    logic [PAT_W-1:0] window;
  } probe_t;

  // Per-cell hit flags
  typedef struct packed {
    logic hnd_hit;
    logic dup_hit;
    logic cls_hit;
  } flags_t;

  // Mask covering the first len bytes of a pattern, byte 0 in the top bits
  function automatic logic [PAT_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PAT_W-1:0] m;
    m = '0;
    for (int j = 0; j < PAT_BYTES_MAX; j++) begin
      if (LEN_W'(j) < len) begin
        m[PAT_W-1-8*j -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

FILE: design/packet_type_demux_table.sv
// Top level of the packet type demux table: a row of entry cells and the request sequencer.
//
//  channel  | ports                                            | direction
//  ---------+--------------------------------------------------+----------
//  request  | in_valid/in_ready, in_command .. in_frame_high   | in
//  result   | out_valid/out_ready, out_status, out_matched_handle | out
//
// Each request passes the idle and apply states: in the cycle it is taken, every
// cell compares its entry against the request and registers its hit flags; in
// apply the first hit is picked, the table is updated and the result register
// loaded. Apply holds while the result register is full and not being taken, and
// no new request is taken before the last is through. Reset clears the entry
// count, the sequencer and the result valid; no clearing pass is needed.
module packet_type_demux_table import ptd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [HND_W-1:0]  in_handle,
  input  logic [LEN_W-1:0]  in_type_len,
  input  logic [63:0]       in_pattern_low,
  input  logic [15:0]       in_pattern_high,
  input  logic [63:0]       in_frame_low,
  input  logic [47:0]       in_frame_high,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] out_status,
  output logic [HND_W-1:0]  out_matched_handle
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMD_W-1:0]  cmd_r;
  entry_t            wr_entry_r;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [HND_W-1:0]  out_handle_r, out_handle_nxt;

  logic   accept, go, too_long, full, do_insert, do_remove;
  probe_t probe;
  entry_t masked_req;
  entry_t cell_entry [TABLE_ENTRIES];
  flags_t cell_flags [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hnd_vec, dup_vec, cls_vec;
  logic [TABLE_ENTRIES-1:0] rm_one, rm_ge, cls_one;
  logic [HND_W-1:0]         cls_handle;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign go       = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // Build the broadcast probe from the request ports
  always_comb begin
    masked_req.handle  = in_handle;
    masked_req.len     = in_type_len;
    masked_req.pattern = {in_pattern_low, in_pattern_high} & byte_mask(in_type_len);
    probe.handle       = in_handle;
    probe.pattern      = masked_req.pattern;
    if (in_frame_low[63:48] >= ETHER_II_MIN) begin
      probe.window = {in_frame_low, in_frame_high[47:32]};
    end else begin
      probe.window = {in_frame_low[47:0], in_frame_high[47:16]};
    end
  end

  // Row of cells, each shifting from its right neighbor
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t next_e;
    if (i == TABLE_ENTRIES - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end

    ptd_cell u_cell (
      .clk        (clk),
      .valid      (count_r > CNT_W'(i)),
      .probe      (probe),
      .capture    (accept),
      .load       (do_insert && (count_r == CNT_W'(i))),
      .load_entry (wr_entry_r),
      .shift      (go && (cmd_r == CMD_REMOVE) && rm_ge[i]),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .flags      (cell_flags[i])
    );

    assign hnd_vec[i] = cell_flags[i].hnd_hit;
    assign dup_vec[i] = cell_flags[i].dup_hit;
    assign cls_vec[i] = cell_flags[i].cls_hit;
  end

  // Pick first hits; cells at or after the removed one shift up
  assign rm_one  = hnd_vec & (~hnd_vec + 1'b1);
  assign rm_ge   = ~(rm_one - 1'b1);
  assign cls_one = cls_vec & (~cls_vec + 1'b1);

  always_comb begin
    cls_handle = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cls_handle = cls_handle | (cell_entry[i].handle & {HND_W{cls_one[i]}});
    end
  end

  assign too_long  = wr_entry_r.len > LEN_W'(PATTERN_BYTES);
  assign full      = count_r >= CNT_W'(TABLE_ENTRIES);
  assign do_insert = go && (cmd_r == CMD_INSERT) && !too_long && !full && !(|dup_vec);
  assign do_remove = go && (cmd_r == CMD_REMOVE) && (|hnd_vec);

  // Sequence the request, update the count and load the result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (go) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          unique case (cmd_r)
            CMD_INSERT: begin
              if (too_long || full) begin
                out_status_nxt = ST_REJECT;
              end else if (|dup_vec) begin
                out_status_nxt = ST_DUP;
              end else begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r + 1'b1;
              end
            end
            CMD_REMOVE: begin
              out_status_nxt = ST_OK;
              if (do_remove) begin
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_CLASSIFY: begin
              if (|cls_vec) begin
                out_status_nxt = ST_OK;
                out_handle_nxt = cls_handle;
              end else begin
                out_status_nxt = ST_NO_MATCH;
              end
            end
            default: begin
              out_status_nxt = ST_NO_MATCH;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold request payload and result data
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      wr_entry_r <= masked_req;
    end
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_matched_handle = out_handle_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_APPLY))
    else $error("taken request did not enter apply");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |->
      (count_r == $past(count_r) + 1'b1 || count_r == $past(count_r) - 1'b1))
    else $error("entry count moved by more than one");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> ($past(state_r) == S_APPLY))
    else $error("result appeared outside apply");

endmodule

FILE: design/ptd_cell.sv
// One table cell: holds an entry, compares it against a request, shifts from its neighbor.
module ptd_cell import ptd_pkg::*; (
  input  logic   clk,
  input  logic   valid,
  input  probe_t probe,
  input  logic   capture,
  input  logic   load,
  input  entry_t load_entry,
  input  logic   shift,
  input  entry_t next_entry,
  output entry_t entry,
  output flags_t flags
);

  entry_t entry_r, entry_nxt;
  flags_t flags_r, flags_nxt;
  logic [PAT_W-1:0] mask;

  // Append takes priority; otherwise pull the neighbor's entry on a remove
  always_comb begin
    entry_nxt = entry_r;
    if (load) begin
      entry_nxt = load_entry;
    end else if (shift) begin
      entry_nxt = next_entry;
    end
  end

  // Compare the held entry against the request
  always_comb begin
    mask              = byte_mask(entry_r.len);
    flags_nxt.hnd_hit = valid && (entry_r.handle == probe.handle);
    flags_nxt.dup_hit = flags_nxt.hnd_hit ||
                        (valid && (entry_r.len > LEN_W'(1)) &&
                         (((entry_r.pattern ^ probe.pattern) & mask) == '0));
    flags_nxt.cls_hit = valid && (((entry_r.pattern ^ probe.window) & mask) == '0);
  end

  // Hold entry and capture flags when a request is taken
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (capture) begin
      flags_r <= flags_nxt;
    end
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule
